// File: rtl/core/msc_pkg.sv
// Shared constants for the merge sort core with move and comparison counts.
`default_nettype none

package msc_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ECNT_W = 11;
  localparam int unsigned MOVE_W = 15;
  localparam int unsigned COMP_W = 14;

  localparam logic [MOVE_W-1:0] MOVES_MAX = '1;
  localparam logic [COMP_W-1:0] COMPS_MAX = '1;

  // Command codes carried in the input tuser bit.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POP  = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/merge_sort_with_counts_core.sv
// Top level: load/pop stream handling, merge sort sequencer and counters.
// A load is taken in the idle state; a pop moves to ST_POUT, where its result enters the output
// register, and waits there while that register is still full and not being taken.
// The load marked last starts the sort of a batch of two or more, and no transfer is accepted
// until it ends: each merge of a range runs through ST_MSTART, ST_MRUN and ST_COPY, and
// each range passes through ST_SCHED, once more when it is split.
// Reset (rst, synchronous) clears counts, flags, the split stack and the output valid;
// the two memories are not cleared and need no clearing pass.
`default_nettype none

module merge_sort_with_counts_core #(
  parameter int unsigned MAX_ELEMENTS = msc_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic [0:0]  s_tuser,   // [0] cmd
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [79:0] m_tdata,   // [31:0] sorted_value, [42:32] element_count,
                                      // [57:43] move_count, [71:58] compare_count,
                                      // [72] overflow, [79:73] zero
  output logic      [0:0]  m_tuser,   // [0] empty_res
  output logic             m_tlast    // is_last
);

  localparam int unsigned AW  = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned SD  = 2 * AW + 2;
  localparam int unsigned SIW = $clog2(SD);
  localparam int unsigned SPW = $clog2(SD + 1);
  localparam int unsigned DW  = msc_pkg::DATA_W;
  localparam int unsigned MW  = msc_pkg::MOVE_W;
  localparam int unsigned KW  = msc_pkg::COMP_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_ELEMENTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_POUT   = 3'd1;
  localparam logic [2:0] ST_SCHED  = 3'd2;
  localparam logic [2:0] ST_MSTART = 3'd3;
  localparam logic [2:0] ST_MRUN   = 3'd4;
  localparam logic [2:0] ST_COPY   = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] loaded_count;
  logic [CW-1:0] read_index;
  logic [MW-1:0] moves;
  logic [KW-1:0] comps;
  logic          sorted_flag;
  logic          overflow_flag;

  // Split stack: each entry is a range and whether its halves are already sorted.
  logic [AW-1:0]  stk_lo [SD];
  logic [AW-1:0]  stk_hi [SD];
  logic           stk_x  [SD];
  logic [SPW-1:0] sp;

  logic [AW-1:0] m_lo, m_mid, m_hi;
  logic [CW-1:0] a, b, k;
  logic [AW-1:0] ci;
  logic          cp_valid;
  logic [AW-1:0] cp_addr;

  logic [AW-1:0] pop_idx;
  logic          pop_last;
  logic          pop_empty;

  logic [DW-1:0] out_value;
  logic          out_last;
  logic [msc_pkg::ECNT_W-1:0] out_ecnt;
  logic [MW-1:0] out_moves;
  logic [KW-1:0] out_comps;
  logic          out_empty;
  logic          out_ovf;

  // Memory side.
  logic [DW-1:0] rd_a, rd_b, scr_rd;
  logic          data_we;
  logic [AW-1:0] data_waddr;
  logic [DW-1:0] data_wdata;
  logic [AW-1:0] rd_a_addr;

  // Handshake and merge datapath.
  logic          in_fire;
  logic          ld_fire;
  logic          pop_fire;
  logic [CW-1:0] ld_base;
  logic          ld_fit;
  logic [CW-1:0] ld_count;
  logic          pop_is_empty;

  logic [SIW-1:0] top_idx;
  logic [AW-1:0]  top_lo, top_hi, top_mid;
  logic           top_x;
  logic [AW:0]    top_sum;

  logic          a_ok, b_ok;
  logic          take_b;
  logic          scr_we;
  logic          cmp_en;
  logic [CW-1:0] a_next, b_next;
  logic [DW-1:0] sel_val;
  logic          mv_en;
  logic [MW-1:0] moves_inc;
  logic [KW-1:0] comps_inc;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign ld_fire  = in_fire && (s_tuser[0] == msc_pkg::CMD_LOAD);
  assign pop_fire = in_fire && (s_tuser[0] == msc_pkg::CMD_POP);

  // A load after a finished sort opens a new batch at index zero.
  assign ld_base      = sorted_flag ? '0 : loaded_count;
  assign ld_fit       = ld_base < CAP;
  assign ld_count     = ld_fit ? ld_base + CW'(1) : ld_base;
  assign pop_is_empty = !sorted_flag || (read_index >= loaded_count);

  assign top_idx = SIW'(sp - SPW'(1));
  assign top_lo  = stk_lo[top_idx];
  assign top_hi  = stk_hi[top_idx];
  assign top_x   = stk_x[top_idx];
  assign top_sum = {1'b0, top_lo} + {1'b0, top_hi};
  assign top_mid = top_sum[AW:1];

  assign moves_inc = (moves != msc_pkg::MOVES_MAX) ? moves + MW'(1) : moves;
  assign comps_inc = (comps != msc_pkg::COMPS_MAX) ? comps + KW'(1) : comps;

  // Merge step: the read addresses for the next cycle follow the head that is taken now,
  // so both heads are always valid in rd_a and rd_b while the merge runs.
  always_comb begin
    a_next = a;
    b_next = b;
    take_b = 1'b0;
    scr_we = 1'b0;
    cmp_en = 1'b0;
    a_ok   = a <= {1'b0, m_mid};
    b_ok   = b <= {1'b0, m_hi};
    case (state)
      ST_MSTART: begin
        a_next = {1'b0, m_lo};
        b_next = {1'b0, m_mid} + CW'(1);
      end
      ST_MRUN: begin
        if (a_ok && b_ok) begin
          cmp_en = 1'b1;
          take_b = !($signed(rd_a) <= $signed(rd_b));
        end else begin
          take_b = !a_ok;
        end
        scr_we = a_ok || b_ok;
        if (scr_we) begin
          if (take_b) begin
            b_next = b + CW'(1);
          end else begin
            a_next = a + CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign sel_val = take_b ? rd_b : rd_a;
  assign mv_en   = scr_we || (state == ST_COPY);

  always_comb begin
    case (state)
      ST_MSTART, ST_MRUN: rd_a_addr = a_next[AW-1:0];
      ST_POUT:            rd_a_addr = pop_idx;
      default:            rd_a_addr = read_index[AW-1:0];
    endcase
  end

  // Loads and copy-back writes never fall in the same cycle.
  assign data_we    = (ld_fire && ld_fit) || cp_valid;
  assign data_waddr = cp_valid ? cp_addr : ld_base[AW-1:0];
  assign data_wdata = cp_valid ? scr_rd : s_tdata;

  msc_store #(
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk        (clk),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (b_next[AW-1:0]),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .scr_we     (scr_we),
    .scr_waddr  (k[AW-1:0]),
    .scr_wdata  (sel_val),
    .scr_raddr  (ci),
    .scr_rd     (scr_rd)
  );

  // Split stack entries.
  always_ff @(posedge clk) begin
    if (ld_fire && s_tlast && (ld_count > CW'(1))) begin
      stk_lo[0] <= '0;
      stk_hi[0] <= AW'(ld_count - CW'(1));
      stk_x[0]  <= 1'b0;
    end else if (state == ST_SCHED && sp != '0 && top_lo < top_hi && !top_x) begin
      // Keep the range for its merge, then push the right half and the left half above it.
      stk_x[top_idx]          <= 1'b1;
      stk_lo[SIW'(sp)]        <= top_mid + AW'(1);
      stk_hi[SIW'(sp)]        <= top_hi;
      stk_x[SIW'(sp)]         <= 1'b0;
      stk_lo[SIW'(sp + SPW'(1))] <= top_lo;
      stk_hi[SIW'(sp + SPW'(1))] <= top_mid;
      stk_x[SIW'(sp + SPW'(1))]  <= 1'b0;
    end
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loaded_count  <= '0;
      read_index    <= '0;
      moves         <= '0;
      comps         <= '0;
      sorted_flag   <= 1'b0;
      overflow_flag <= 1'b0;
      sp            <= '0;
      cp_valid      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      cp_valid <= (state == ST_COPY);
      if (m_tvalid && m_tready && (state != ST_POUT)) begin
        m_tvalid <= 1'b0;
      end
      if (mv_en) begin
        moves <= moves_inc;
      end
      if (cmp_en) begin
        comps <= comps_inc;
      end
      a <= a_next;
      b <= b_next;
      if (scr_we) begin
        k <= k + CW'(1);
      end

      case (state)
        ST_IDLE: begin
          if (ld_fire) begin
            loaded_count  <= ld_count;
            overflow_flag <= (sorted_flag ? 1'b0 : overflow_flag) || !ld_fit;
            if (sorted_flag) begin
              moves <= '0;
              comps <= '0;
            end
            if (sorted_flag || s_tlast) begin
              read_index <= '0;
            end
            // A batch of one element needs no sort and is ready at once.
            sorted_flag <= s_tlast && (ld_count <= CW'(1));
            if (s_tlast && (ld_count > CW'(1))) begin
              sp    <= SPW'(1);
              state <= ST_SCHED;
            end
          end else if (pop_fire) begin
            pop_idx   <= read_index[AW-1:0];
            pop_empty <= pop_is_empty;
            pop_last  <= !pop_is_empty && (read_index + CW'(1) == loaded_count);
            if (!pop_is_empty) begin
              read_index <= read_index + CW'(1);
            end
            state <= ST_POUT;
          end
        end

        ST_POUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_value <= pop_empty ? '0 : rd_a;
            out_last  <= pop_last;
            out_ecnt  <= msc_pkg::ECNT_W'(loaded_count);
            out_moves <= moves;
            out_comps <= comps;
            out_empty <= pop_empty;
            out_ovf   <= overflow_flag;
            state     <= ST_IDLE;
          end
        end

        ST_SCHED: begin
          if (sp == '0) begin
            sorted_flag <= 1'b1;
            read_index  <= '0;
            state       <= ST_IDLE;
          end else if (top_lo >= top_hi) begin
            sp <= sp - SPW'(1);
          end else if (!top_x) begin
            sp <= sp + SPW'(2);
          end else begin
            m_lo  <= top_lo;
            m_mid <= top_mid;
            m_hi  <= top_hi;
            sp    <= sp - SPW'(1);
            state <= ST_MSTART;
          end
        end

        ST_MSTART: begin
          k     <= '0;
          state <= ST_MRUN;
        end

        ST_MRUN: begin
          if (!a_ok && !b_ok) begin
            ci    <= '0;
            state <= ST_COPY;
          end
        end

        ST_COPY: begin
          // Scratch data read now is written back to the element store next cycle.
          cp_addr  <= m_lo + ci;
          ci       <= ci + AW'(1);
          if (ci == m_hi - m_lo) begin
            state <= ST_SCHED;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'd0, out_ovf, out_comps, out_moves, out_ecnt, out_value};
  assign m_tuser = out_empty;
  assign m_tlast = out_last;

  a_no_last_when_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tlast && m_tuser[0]))
    else $error("result marked both last and empty");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(SD))
    else $error("split stack overflow");

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (sp == '0))
    else $error("accepting transfers with split stack not empty");

  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MRUN) |->
      (k == CW'(a - {1'b0, m_lo} + b - {1'b0, m_mid} - CW'(1))))
    else $error("merge output count does not match consumed heads");

  a_read_index_bound: assert property (@(posedge clk) disable iff (rst)
    sorted_flag |-> (read_index <= loaded_count))
    else $error("read index beyond loaded count");

endmodule

`default_nettype wire

// File: rtl/core/msc_store.sv
// Element store and scratch store: synchronous memories with registered read data.
`default_nettype none

module msc_store #(
  parameter int unsigned DEPTH = msc_pkg::MAX_ELEMENTS_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        data_we,
  input  wire logic [AW-1:0]               data_waddr,
  input  wire logic [msc_pkg::DATA_W-1:0]  data_wdata,
  input  wire logic [AW-1:0]               rd_a_addr,
  input  wire logic [AW-1:0]               rd_b_addr,
  output logic      [msc_pkg::DATA_W-1:0]  rd_a,
  output logic      [msc_pkg::DATA_W-1:0]  rd_b,
  input  wire logic                        scr_we,
  input  wire logic [AW-1:0]               scr_waddr,
  input  wire logic [msc_pkg::DATA_W-1:0]  scr_wdata,
  input  wire logic [AW-1:0]               scr_raddr,
  output logic      [msc_pkg::DATA_W-1:0]  scr_rd
);

  logic [msc_pkg::DATA_W-1:0] data_mem    [DEPTH];
  logic [msc_pkg::DATA_W-1:0] scratch_mem [DEPTH];

  // Element store: one write port, two read ports.
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    rd_a <= data_mem[rd_a_addr];
    rd_b <= data_mem[rd_b_addr];
  end

  // Scratch store: one write port, one read port.
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scratch_mem[scr_waddr] <= scr_wdata;
    end
    scr_rd <= scratch_mem[scr_raddr];
  end

endmodule

`default_nettype wire
